@@ sv/vlfd_pkg.sv @@
// ----------------------------------------------------------------------------
// vlfd_pkg
// Types and constants for the varint length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package vlfd_pkg;

  localparam int unsigned LEN_W      = 32;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned GROUP_W    = 7;
  localparam logic [7:0]  DATA_MASK  = 8'h7F;
  localparam logic [7:0]  MORE_MASK  = 8'h80;
  localparam logic [CNT_W-1:0] MAX_PREFIX = 3'd5;

  typedef enum logic {
    PH_LENGTH  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       connection_closed;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_last;
    logic       length_error;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t item;
  } res_t;

endpackage

@@ sv/vlfd_core.sv @@
// ----------------------------------------------------------------------------
// vlfd_core
// Frame state: length prefix parsing and payload countdown. Gives the result
// for the presented byte combinationally and updates state on a transfer.
// ----------------------------------------------------------------------------
module vlfd_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  vlfd_pkg::in_t item,
  output vlfd_pkg::res_t result
);

  vlfd_pkg::phase_t                  phase, phase_next;
  logic [vlfd_pkg::LEN_W-1:0]        acc, acc_next;
  logic [vlfd_pkg::CNT_W-1:0]        count, count_next;
  logic [vlfd_pkg::LEN_W-1:0]        remaining, remaining_next;

  logic [vlfd_pkg::LEN_W-1:0]        group;
  logic [vlfd_pkg::LEN_W-1:0]        acc_or;
  logic [vlfd_pkg::CNT_W-1:0]        count_inc;
  logic                              more;

  always_comb begin
    group = {{(vlfd_pkg::LEN_W-8){1'b0}}, item.data_byte & vlfd_pkg::DATA_MASK};
    // fifth group loses its top bits above bit 31 through the shift
    case (count)
      3'd0:    acc_or = acc | group;
      3'd1:    acc_or = acc | (group << vlfd_pkg::GROUP_W);
      3'd2:    acc_or = acc | (group << (2 * vlfd_pkg::GROUP_W));
      3'd3:    acc_or = acc | (group << (3 * vlfd_pkg::GROUP_W));
      3'd4:    acc_or = acc | (group << (4 * vlfd_pkg::GROUP_W));
      default: acc_or = acc;
    endcase
    count_inc = count + 3'd1;
    more      = (item.data_byte & vlfd_pkg::MORE_MASK) != 8'h00;
  end

  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    count_next     = count;
    remaining_next = remaining;
    result         = '0;
    if (item.connection_closed) begin
      phase_next     = vlfd_pkg::PH_LENGTH;
      acc_next       = '0;
      count_next     = '0;
      remaining_next = '0;
    end else if (phase == vlfd_pkg::PH_PAYLOAD) begin
      result.valid             = 1'b1;
      result.item.payload_byte = item.data_byte;
      if (remaining <= 1) begin
        remaining_next         = '0;
        phase_next             = vlfd_pkg::PH_LENGTH;
        result.item.frame_last = 1'b1;
      end else begin
        remaining_next = remaining - 1'b1;
      end
    end else begin
      acc_next   = acc_or;
      count_next = count_inc;
      if (!more) begin
        acc_next   = '0;
        count_next = '0;
        if (acc_or != '0) begin
          remaining_next = acc_or;
          phase_next     = vlfd_pkg::PH_PAYLOAD;
        end
      end else if (count_inc >= vlfd_pkg::MAX_PREFIX) begin
        acc_next                 = '0;
        count_next               = '0;
        result.valid             = 1'b1;
        result.item.length_error = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= vlfd_pkg::PH_LENGTH;
      acc       <= '0;
      count     <= '0;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      acc       <= acc_next;
      count     <= count_next;
      remaining <= remaining_next;
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.connection_closed |=>
      phase == vlfd_pkg::PH_LENGTH && acc == '0 && count == '0 && remaining == '0)
    else $error("close did not clear frame state");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == vlfd_pkg::PH_PAYLOAD |-> remaining != '0)
    else $error("payload phase with nothing remaining");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < vlfd_pkg::MAX_PREFIX)
    else $error("prefix count out of range");

  a_payload_prefix_clear: assert property (@(posedge clk) disable iff (rst)
    phase == vlfd_pkg::PH_PAYLOAD |-> acc == '0 && count == '0)
    else $error("prefix state left over in payload phase");

endmodule

@@ sv/varint_length_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// varint_length_frame_deframer
// Splits a byte stream into frames that open with a VarInt length prefix.
// ----------------------------------------------------------------------------
//
//  channel | signals                      | carries
//  --------+------------------------------+-----------------------------------
//  rx      | rx_valid, rx_ready, rx       | stream byte, connection closed
//  frame   | frame_valid, frame_ready, fr | payload byte, last mark, error
//
//  One byte per cycle while rx_ready is high: each transfer is handled in
//  the cycle it is taken; its result is in an output register the next cycle.
//  Only payload bytes and the 5th byte of a too-long prefix give a result.
//  rx_ready drops only while a held result is not being taken.
//  rst (synchronous) returns to length parsing and empties the output.
// ----------------------------------------------------------------------------
module varint_length_frame_deframer (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_ready,
  input  vlfd_pkg::in_t  rx,
  output logic           frame_valid,
  input  logic           frame_ready,
  output vlfd_pkg::out_t frame
);

  vlfd_pkg::res_t result;
  logic           accept;

  assign rx_ready = !frame_valid || frame_ready;
  assign accept   = rx_valid && rx_ready;

  vlfd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (rx),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (rx_ready) begin
      frame_valid <= accept && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.valid) begin
      frame <= result.item;
    end
  end

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame.length_error |-> frame.payload_byte == 8'h00 && !frame.frame_last)
    else $error("error result carries payload fields");

  a_result_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !$past(frame_valid) |-> $past(accept))
    else $error("result without a transfer");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |-> !rx_ready)
    else $error("input taken while result stalled");

endmodule
